// ----- hdl/caldc_pkg.sv -----
// ----------------------------------------------------------------------------
// caldc_pkg - shared constants and helpers for the calendar date classifier
// Month and country codes, month tables and small modulo helpers.
// ----------------------------------------------------------------------------
package caldc_pkg;

    // zero-based month codes
    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_MAR = 4'd2;
    localparam logic [3:0] MON_APR = 4'd3;
    localparam logic [3:0] MON_MAY = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd5;
    localparam logic [3:0] MON_JUL = 4'd6;
    localparam logic [3:0] MON_AUG = 4'd7;
    localparam logic [3:0] MON_SEP = 4'd8;
    localparam logic [3:0] MON_OCT = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd10;
    localparam logic [3:0] MON_DEC = 4'd11;

    // holiday rule sets
    localparam logic [1:0] COUNTRY_NONE = 2'd0;
    localparam logic [1:0] COUNTRY_FR   = 2'd1;
    localparam logic [1:0] COUNTRY_US   = 2'd2;
    localparam logic [1:0] COUNTRY_RSVD = 2'd3;   // unassigned, acts as none

    // month length in a common year
    function automatic logic [4:0] month_len(input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            MON_FEB: len = 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // (153 * mm + 2) / 5 for the March-based month index
    function automatic logic [8:0] month_offset(input logic [3:0] mm);
        logic [8:0] ofs;
        case (mm)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            default: ofs = 9'd337;
        endcase
        return ofs;
    endfunction

    // x mod 7 for x below 112, by restoring subtraction
    function automatic logic [2:0] mod7_small(input logic [6:0] x);
        logic [6:0] v;
        v = x;
        if (v >= 7'd56) v = v - 7'd56;
        if (v >= 7'd28) v = v - 7'd28;
        if (v >= 7'd14) v = v - 7'd14;
        if (v >= 7'd7)  v = v - 7'd7;
        return v[2:0];
    endfunction

    // does day/month equal the date lying off days after March 1
    function automatic logic offset_hit(input logic [6:0] off, input logic [4:0] day,
                                        input logic [3:0] mon);
        logic [3:0] hm;
        logic [6:0] hd;
        if (off < 7'd31) begin
            hm = MON_MAR;
            hd = off + 7'd1;
        end else if (off < 7'd61) begin
            hm = MON_APR;
            hd = off - 7'd30;
        end else if (off < 7'd92) begin
            hm = MON_MAY;
            hd = off - 7'd60;
        end else begin
            hm = MON_JUN;
            hd = off - 7'd91;
        end
        return (hm == mon) && (hd == 7'(day));
    endfunction

endpackage

// ----- hdl/caldc_const_div.sv -----
// ----------------------------------------------------------------------------
// caldc_const_div - two-stage division by a constant
// Reciprocal multiply, then one compare-and-subtract correction.
// ----------------------------------------------------------------------------
module caldc_const_div #(
    parameter int unsigned W   = 16,
    parameter int unsigned DIV = 7,
    parameter int unsigned QW  = 14,
    parameter int unsigned RW  = 3
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [W-1:0]  x,
    output logic [QW-1:0] q,
    output logic [RW-1:0] r
);

    // floor(2^W / DIV): estimate is exact or one low for any x below 2^W
    localparam int unsigned RECIP = (2 ** W) / DIV;
    localparam int unsigned MW    = $clog2(RECIP + 1);
    localparam int unsigned PW    = W + MW;

    logic [W-1:0]  x_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] prod_next;
    logic [QW-1:0] q_est;
    logic [W-1:0]  r_est;
    logic [QW-1:0] q_reg;
    logic [QW-1:0] q_next;
    logic [RW-1:0] r_reg;
    logic [RW-1:0] r_next;

    assign prod_next = PW'(x) * PW'(RECIP);

    always_comb begin
        q_est = QW'(prod_reg >> W);
        r_est = x_reg - W'(W'(q_est) * W'(DIV));
        if (r_est >= W'(DIV)) begin
            q_next = QW'(q_est + 1'b1);
            r_next = RW'(r_est - W'(DIV));
        end else begin
            q_next = q_est;
            r_next = RW'(r_est);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x;
            prod_reg <= prod_next;
            q_reg    <= q_next;
            r_reg    <= r_next;
        end
    end

    assign q = q_reg;
    assign r = r_reg;

endmodule

// ----- hdl/calendar_date_classifier.sv -----
// ----------------------------------------------------------------------------
// calendar_date_classifier - date to calendar facts, thirteen-stage pipeline
// Julian day, weekday, ISO week, month length, leap year and holiday flag.
// ----------------------------------------------------------------------------
// Usage notes:
//   Input channel s_*: one Gregorian date per item (day, zero-based month,
//   year). Months above December are treated as December.
//   Output channel m_*: one result item per date, in order.
//   Throughput: one item per cycle; a new date is taken every cycle as long
//   as the output side keeps up. The depth is set by the ISO week path:
//   constant divisions in series (year/100, weekday, 400-year cycle,
//   four-year block, week).
//   Stall: when the output item is held (m_valid high, m_ready low) the whole
//   pipeline freezes and s_ready drops; nothing is lost or repeated.
//   Config: cfg_wr_en/cfg_wr_data write the holiday rule set (0 none,
//   1 France, 2 USA, 3 acts as none). Write only while no items are in flight.
//   Reset (aresetn low, synchronous): pipeline emptied, rule set = France.
// ----------------------------------------------------------------------------
module calendar_date_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_date_day,
    input  logic [3:0]  s_date_month,
    input  logic [13:0] s_date_year,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [22:0] m_julian_day,
    output logic [2:0]  m_day_of_week,
    output logic [5:0]  m_iso_week,
    output logic [4:0]  m_days_in_month,
    output logic        m_leap_year,
    output logic        m_non_working
);

    // global advance: every stage moves together
    logic        adv;
    logic [13:1] vld_reg;
    logic [1:0]  country_reg;

    // stage 0: month saturation, March-based year and month
    logic [3:0]  mon_sat;
    logic        jan_feb;
    logic [14:0] yy0;
    logic [3:0]  mm0;
    logic        fx_common;
    logic        fxfr_next;
    logic        fxus_next;

    logic [4:0]  d_reg      [1:9];
    logic [3:0]  m_reg      [1:9];
    logic [13:0] y_reg      [1:2];
    logic [14:0] yy_reg     [1:2];
    logic [8:0]  t153_reg   [1:2];
    logic        fxfr_reg   [1:10];
    logic        fxus_reg   [1:10];
    logic [22:0] yy365_reg;

    // stage 2 results of the year divisions
    logic [7:0]  q_yy100;
    logic [7:0]  q_y100;
    logic [6:0]  r_y100;
    logic [4:0]  r_y19;
    logic [22:0] j_next;
    logic        leap_next;
    logic [4:0]  mdays_next;
    logic [8:0]  b_plus8;
    logic [2:0]  ef_next;

    logic [22:0] j_reg      [3:13];
    logic        leap_reg   [3:13];
    logic [4:0]  mdays_reg  [3:13];
    logic [4:0]  ea_reg     [3:8];
    logic [7:0]  eb_reg     [3:5];
    logic [1:0]  ee_reg     [3:7];
    logic [4:0]  ei_reg     [3:7];
    logic [1:0]  ek_reg     [3:7];
    logic [2:0]  ef_reg;
    logic [8:0]  a19_reg    [4:5];

    // stage 5
    logic [2:0]  wd5;
    logic [5:0]  g5;
    logic [2:0]  jm7;
    logic [22:0] iso_x;
    logic [9:0]  h_pre;
    logic [2:0]  w1_next;
    logic [2:0]  wl_next;
    logic [2:0]  wd_reg     [6:13];
    logic [2:0]  w1_reg;
    logic [2:0]  wl_reg;

    // stage 6: USA floating days
    logic [2:0]  fm;
    logic [2:0]  fth;
    logic [2:0]  lmo;
    logic [5:0]  first_mon;
    logic [5:0]  thanks;
    logic [5:0]  day6;
    logic        usa_next;
    logic        usa_reg    [7:10];

    // stage 7..10: ISO week reduction and Easter
    logic [17:0] r146;
    logic [4:0]  h7;
    logic [15:0] d4a_next;
    logic [2:0]  re_next;
    logic [15:0] d4a_reg;
    logic [4:0]  h_reg;
    logic [2:0]  re_reg;
    logic [9:0]  nsum;
    logic [5:0]  off_next;
    logic [5:0]  off_reg;
    logic        frm_next;
    logic        frm_reg;
    logic [10:0] d4;
    logic        l_last;
    logic [10:0] d4v;
    logic [10:0] d4m;
    logic [8:0]  d1_next;
    logic [8:0]  d1_reg;
    logic        hol_next;
    logic        hol_reg    [11:13];
    logic [5:0]  q_week;

    assign adv     = !vld_reg[13] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[13];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            country_reg <= caldc_pkg::COUNTRY_FR;
        end else begin
            if (adv) begin
                vld_reg <= {vld_reg[12:1], s_valid};
            end
            if (cfg_wr_en) begin
                country_reg <= cfg_wr_data;
            end
        end
    end

    // ---- stage 0 -----------------------------------------------------------
    always_comb begin
        mon_sat = (s_date_month > caldc_pkg::MON_DEC) ? caldc_pkg::MON_DEC : s_date_month;
        jan_feb = (mon_sat < caldc_pkg::MON_MAR);
        yy0     = 15'(s_date_year) + 15'd4800 - 15'(jan_feb);
        mm0     = jan_feb ? (mon_sat + 4'd10) : (mon_sat - 4'd2);
        // fixed days shared by both rule sets
        fx_common = ((s_date_day == 5'd1)  && (mon_sat == caldc_pkg::MON_JAN)) ||
                    ((s_date_day == 5'd11) && (mon_sat == caldc_pkg::MON_NOV)) ||
                    ((s_date_day == 5'd25) && (mon_sat == caldc_pkg::MON_DEC));
        fxfr_next = fx_common ||
                    ((s_date_day == 5'd1)  && (mon_sat == caldc_pkg::MON_MAY)) ||
                    ((s_date_day == 5'd8)  && (mon_sat == caldc_pkg::MON_MAY)) ||
                    ((s_date_day == 5'd14) && (mon_sat == caldc_pkg::MON_JUL)) ||
                    ((s_date_day == 5'd15) && (mon_sat == caldc_pkg::MON_AUG)) ||
                    ((s_date_day == 5'd1)  && (mon_sat == caldc_pkg::MON_NOV));
        fxus_next = fx_common ||
                    ((s_date_day == 5'd4)  && (mon_sat == caldc_pkg::MON_JUL));
    end

    // year divisions: yy/100 for the Julian day, y/100 and y/19 for leap and Easter
    caldc_const_div #(.W(15), .DIV(100), .QW(8), .RW(7)) u_div_yy100 (
        .aclk(aclk), .en(adv), .x(yy0), .q(q_yy100), .r()
    );
    caldc_const_div #(.W(14), .DIV(100), .QW(8), .RW(7)) u_div_y100 (
        .aclk(aclk), .en(adv), .x(s_date_year), .q(q_y100), .r(r_y100)
    );
    caldc_const_div #(.W(14), .DIV(19), .QW(10), .RW(5)) u_div_y19 (
        .aclk(aclk), .en(adv), .x(s_date_year), .q(), .r(r_y19)
    );

    // ---- stage 2: Julian day, leap, month length, Easter terms -------------
    always_comb begin
        j_next = 23'(d_reg[2]) + 23'(t153_reg[2]) + yy365_reg + 23'(yy_reg[2] >> 2)
               - 23'(q_yy100) + 23'(q_yy100 >> 2) - 23'd32045;
        // y % 400 == 0 is y % 100 == 0 with (y / 100) % 4 == 0
        leap_next  = ((y_reg[2][1:0] == 2'd0) && (r_y100 != 7'd0)) ||
                     ((r_y100 == 7'd0) && (q_y100[1:0] == 2'd0));
        mdays_next = caldc_pkg::month_len(m_reg[2]) +
                     5'((m_reg[2] == caldc_pkg::MON_FEB) && leap_next);
        // f = (b + 8) / 25, b at most 163
        b_plus8 = 9'(q_y100) + 9'd8;
        ef_next = 3'(b_plus8 >= 9'd25) + 3'(b_plus8 >= 9'd50) + 3'(b_plus8 >= 9'd75) +
                  3'(b_plus8 >= 9'd100) + 3'(b_plus8 >= 9'd125) + 3'(b_plus8 >= 9'd150);
    end

    // ---- stage 3: weekday division and g = (b - f + 1) / 3 -----------------
    caldc_const_div #(.W(23), .DIV(7), .QW(21), .RW(3)) u_div_wd (
        .aclk(aclk), .en(adv), .x(j_reg[3] + 23'd1), .q(), .r(wd5)
    );
    caldc_const_div #(.W(8), .DIV(3), .QW(6), .RW(2)) u_div_g (
        .aclk(aclk), .en(adv), .x(eb_reg[3] - 8'(ef_reg) + 8'd1), .q(g5), .r()
    );

    // ---- stage 5: ISO shift, Easter h, weekday of month ends ---------------
    always_comb begin
        jm7   = (wd5 == 3'd0) ? 3'd6 : (wd5 - 3'd1);
        iso_x = j_reg[5] + 23'd31741 - 23'(jm7);
        h_pre = 10'(a19_reg[5]) + 10'(eb_reg[5]) - 10'(eb_reg[5] >> 2) - 10'(g5) + 10'd15;
        // weekday of the 1st and of the last day, from the date's own weekday
        w1_next = caldc_pkg::mod7_small(7'(wd5) + 7'd36 - 7'(d_reg[5]));
        wl_next = caldc_pkg::mod7_small(7'(wd5) + 7'(mdays_reg[5]) + 7'd35 - 7'(d_reg[5]));
    end

    caldc_const_div #(.W(23), .DIV(146097), .QW(6), .RW(18)) u_div_cycle (
        .aclk(aclk), .en(adv), .x(iso_x), .q(), .r(r146)
    );
    caldc_const_div #(.W(10), .DIV(30), .QW(5), .RW(5)) u_div_h (
        .aclk(aclk), .en(adv), .x(h_pre), .q(), .r(h7)
    );

    // ---- stage 6: USA floating holidays ------------------------------------
    always_comb begin
        fm        = caldc_pkg::mod7_small(7'd8 - 7'(w1_reg));
        fth       = caldc_pkg::mod7_small(7'd11 - 7'(w1_reg));
        lmo       = caldc_pkg::mod7_small(7'(wl_reg) + 7'd6);
        first_mon = 6'd1 + 6'(fm);
        thanks    = 6'd22 + 6'(fth);
        day6      = 6'(d_reg[6]);
        case (m_reg[6])
            caldc_pkg::MON_JAN, caldc_pkg::MON_FEB: usa_next = (day6 == first_mon + 6'd14);
            caldc_pkg::MON_MAY: usa_next = (day6 == 6'(mdays_reg[6]) - 6'(lmo));
            caldc_pkg::MON_SEP: usa_next = (day6 == first_mon);
            caldc_pkg::MON_OCT: usa_next = (day6 == first_mon + 6'd7);
            caldc_pkg::MON_NOV: usa_next = (day6 == thanks) || (day6 == thanks + 6'd1);
            default:            usa_next = 1'b0;
        endcase
    end

    // ---- stage 7: century fold, Easter r -----------------------------------
    always_comb begin
        if (r146 >= 18'd146096) begin
            d4a_next = 16'(r146 - 18'd146096);
        end else if (r146 >= 18'd109572) begin
            d4a_next = 16'(r146 - 18'd109572);
        end else if (r146 >= 18'd73048) begin
            d4a_next = 16'(r146 - 18'd73048);
        end else if (r146 >= 18'd36524) begin
            d4a_next = 16'(r146 - 18'd36524);
        end else begin
            d4a_next = 16'(r146);
        end
        re_next = caldc_pkg::mod7_small(7'd32 + 7'({ee_reg[7], 1'b0}) +
                  7'({ei_reg[7], 1'b0}) - 7'(h7) - 7'(ek_reg[7]));
    end

    // ---- stage 8: four-year fold, Easter offset from March 1 ---------------
    caldc_const_div #(.W(16), .DIV(1461), .QW(5), .RW(11)) u_div_quad (
        .aclk(aclk), .en(adv), .x(d4a_reg), .q(), .r(d4)
    );

    always_comb begin
        nsum     = 10'(h_reg) * 10'd11 + 10'(re_reg) * 10'd22 + 10'(ea_reg[8]);
        // both Easter month branches reduce to t - 93
        off_next = 6'(h_reg) + 6'(re_reg) + 6'd21 - ((nsum >= 10'd451) ? 6'd7 : 6'd0);
    end

    // ---- stage 9: Easter Monday, Ascension, Whit Monday --------------------
    assign frm_next = caldc_pkg::offset_hit(7'(off_reg) + 7'd1,  d_reg[9], m_reg[9]) ||
                      caldc_pkg::offset_hit(7'(off_reg) + 7'd39, d_reg[9], m_reg[9]) ||
                      caldc_pkg::offset_hit(7'(off_reg) + 7'd50, d_reg[9], m_reg[9]);

    // ---- stage 10: day of ISO year, holiday select --------------------------
    always_comb begin
        l_last = (d4 == 11'd1460);
        d4v    = d4 - 11'(l_last);
        if (d4v >= 11'd1095) begin
            d4m = d4v - 11'd1095;
        end else if (d4v >= 11'd730) begin
            d4m = d4v - 11'd730;
        end else if (d4v >= 11'd365) begin
            d4m = d4v - 11'd365;
        end else begin
            d4m = d4v;
        end
        d1_next = 9'(d4m) + 9'(l_last);
        case (country_reg)
            caldc_pkg::COUNTRY_FR: hol_next = fxfr_reg[10] || frm_reg;
            caldc_pkg::COUNTRY_US: hol_next = fxus_reg[10] || usa_reg[10];
            default:               hol_next = 1'b0;
        endcase
    end

    // ---- stage 11: week = day / 7 + 1 ---------------------------------------
    caldc_const_div #(.W(9), .DIV(7), .QW(6), .RW(3)) u_div_week (
        .aclk(aclk), .en(adv), .x(d1_reg), .q(q_week), .r()
    );

    // ---- payload registers -------------------------------------------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg[1]    <= s_date_day;
            m_reg[1]    <= mon_sat;
            y_reg[1]    <= s_date_year;
            yy_reg[1]   <= yy0;
            t153_reg[1] <= caldc_pkg::month_offset(mm0);
            fxfr_reg[1] <= fxfr_next;
            fxus_reg[1] <= fxus_next;
            for (int k = 2; k <= 9; k++) begin
                d_reg[k] <= d_reg[k-1];
                m_reg[k] <= m_reg[k-1];
            end
            for (int k = 2; k <= 10; k++) begin
                fxfr_reg[k] <= fxfr_reg[k-1];
                fxus_reg[k] <= fxus_reg[k-1];
            end
            y_reg[2]    <= y_reg[1];
            yy_reg[2]   <= yy_reg[1];
            t153_reg[2] <= t153_reg[1];
            yy365_reg   <= 23'(yy_reg[1]) * 23'd365;

            j_reg[3]     <= j_next;
            leap_reg[3]  <= leap_next;
            mdays_reg[3] <= mdays_next;
            for (int k = 4; k <= 13; k++) begin
                j_reg[k]     <= j_reg[k-1];
                leap_reg[k]  <= leap_reg[k-1];
                mdays_reg[k] <= mdays_reg[k-1];
            end
            ea_reg[3] <= r_y19;
            eb_reg[3] <= q_y100;
            ee_reg[3] <= q_y100[1:0];
            ei_reg[3] <= 5'(r_y100 >> 2);
            ek_reg[3] <= r_y100[1:0];
            ef_reg    <= ef_next;
            for (int k = 4; k <= 8; k++) begin
                ea_reg[k] <= ea_reg[k-1];
            end
            for (int k = 4; k <= 5; k++) begin
                eb_reg[k] <= eb_reg[k-1];
            end
            for (int k = 4; k <= 7; k++) begin
                ee_reg[k] <= ee_reg[k-1];
                ei_reg[k] <= ei_reg[k-1];
                ek_reg[k] <= ek_reg[k-1];
            end
            a19_reg[4] <= 9'(ea_reg[3]) * 9'd19;
            a19_reg[5] <= a19_reg[4];

            wd_reg[6] <= wd5;
            for (int k = 7; k <= 13; k++) begin
                wd_reg[k] <= wd_reg[k-1];
            end
            w1_reg <= w1_next;
            wl_reg <= wl_next;

            usa_reg[7] <= usa_next;
            for (int k = 8; k <= 10; k++) begin
                usa_reg[k] <= usa_reg[k-1];
            end
            d4a_reg <= d4a_next;
            h_reg   <= h7;
            re_reg  <= re_next;
            off_reg <= off_next;
            frm_reg <= frm_next;
            d1_reg  <= d1_next;

            hol_reg[11] <= hol_next;
            for (int k = 12; k <= 13; k++) begin
                hol_reg[k] <= hol_reg[k-1];
            end
        end
    end

    assign m_julian_day    = j_reg[13];
    assign m_day_of_week   = wd_reg[13];
    assign m_iso_week      = q_week + 6'd1;
    assign m_days_in_month = mdays_reg[13];
    assign m_leap_year     = leap_reg[13];
    assign m_non_working   = hol_reg[13];

    // ---- assertions ----------------------------------------------------------
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[1])
        else $error("accepted item did not enter the pipeline");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_feb_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[3] && (m_reg[3] == caldc_pkg::MON_FEB)) |->
        (mdays_reg[3] == 5'd28 + 5'(leap_reg[3])))
        else $error("February length disagrees with leap flag");

    a_week_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_iso_week != 6'd0) && (m_iso_week <= 6'd53)))
        else $error("ISO week out of range");

endmodule
